// File: rtl/ieec_pkg.sv
// Shared types and constants for the injected event echo canceller.
`timescale 1ns / 1ps

package ieec_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_CHECK  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic REG_SCAN_LIMIT = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    localparam int PADDR_W = 3;

    // Field widths.
    localparam int FUNC_W    = 2;
    localparam int ENTRY_W   = 64;
    localparam int SCAN_W    = 6;
    localparam int TIMEOUT_W = 16;
    localparam int ELAPSED_W = 17;
    localparam int OUT_W     = 8;

    // Reset values of the configuration registers.
    localparam logic [SCAN_W-1:0]    SCAN_LIMIT_RST = 6'd24;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd2000;

    // Saturation point of the elapsed-time counter.
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input transfer
        logic record;      // append the captured event to the ring
        logic tick;        // advance elapsed time by one millisecond
        logic flush;       // empty the ring
        logic scan_start;  // set up the scan pointers at the head
        logic scan_step;   // one scan cycle: issue a read, compare the last one
        logic emit;        // load the result into the output register
        logic res_matched;
        logic res_flushed;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              timed_out;
        logic              hit;
        logic              scan_idle;
        logic              out_free;
    } t_status;

endpackage

// File: rtl/ieec_ctrl.sv
// Controller state machine that sequences record, check and tick operations.
`timescale 1ns / 1ps

module ieec_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  ieec_pkg::t_status  i_status,
    output ieec_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_res_matched;
    logic   r_res_flushed;
    logic   n_res_matched;
    logic   n_res_flushed;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && (r_state == ST_IDLE);

    // Next state, result flags and datapath commands.
    always_comb begin
        n_state       = r_state;
        n_res_matched = r_res_matched;
        n_res_flushed = r_res_flushed;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load    = 1'b1;
                    n_res_matched = 1'b0;
                    n_res_flushed = 1'b0;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_RESULT;
                unique case (i_status.func)
                    ieec_pkg::FUNC_RECORD: o_cmd.record = 1'b1;
                    ieec_pkg::FUNC_TICK:   o_cmd.tick = 1'b1;
                    ieec_pkg::FUNC_CHECK: begin
                        // An empty ring gives no match and skips the timeout test.
                        priority if (i_status.empty) begin
                            n_state = ST_RESULT;
                        end else if (i_status.timed_out) begin
                            o_cmd.flush   = 1'b1;
                            n_res_flushed = 1'b1;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                    end
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                priority if (i_status.hit) begin
                    n_res_matched = 1'b1;
                    n_state       = ST_RESULT;
                end else if (i_status.scan_idle) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // Wait until the output register can take the result.
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.res_matched = r_res_matched;
        o_cmd.res_flushed = r_res_flushed;
    end

    // State and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_res_matched <= 1'b0;
            r_res_flushed <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_res_matched <= n_res_matched;
            r_res_flushed <= n_res_flushed;
        end
    end

endmodule

// File: rtl/ieec_datapath.sv
// Datapath: event ring memory, ring pointers, elapsed timer, scan logic and output register.
`timescale 1ns / 1ps

module ieec_datapath #(
    parameter int RING_DEPTH = 1024,
    parameter int SCAN_MAX   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ieec_pkg::ENTRY_W-1:0]     i_s_tdata,
    input  logic [ieec_pkg::FUNC_W-1:0]      i_s_tuser,
    input  logic [ieec_pkg::SCAN_W-1:0]      i_cfg_scan_limit,
    input  logic [ieec_pkg::TIMEOUT_W-1:0]   i_cfg_timeout,
    input  ieec_pkg::t_cmd                   i_cmd,
    output ieec_pkg::t_status                o_status,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [ieec_pkg::OUT_W-1:0]       o_m_tdata
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(SCAN_MAX + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [ieec_pkg::SCAN_W:0] SCAN_MAX_X = (ieec_pkg::SCAN_W + 1)'(SCAN_MAX);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    logic [ieec_pkg::ENTRY_W-1:0]   r_mem [RING_DEPTH];
    logic [ieec_pkg::FUNC_W-1:0]    r_func;
    logic [ieec_pkg::ENTRY_W-1:0]   r_entry;
    logic [IDX_W-1:0]               r_head;
    logic [IDX_W-1:0]               r_tail;
    logic [ieec_pkg::ELAPSED_W-1:0] r_elapsed;
    logic [IDX_W-1:0]               r_rd_ptr;
    logic [CNT_W-1:0]               r_rd_cnt;
    logic [CNT_W-1:0]               r_limit;
    logic                           r_cmp_vld;
    logic [IDX_W-1:0]               r_cmp_ptr;
    logic [ieec_pkg::ENTRY_W-1:0]   r_rd_data;
    logic                           r_out_vld;
    logic [1:0]                     r_out_data;

    logic [IDX_W-1:0]               tail_next;
    logic [ieec_pkg::SCAN_W:0]      limit_x;
    logic                           can_issue;
    logic                           hit;
    logic                           issue;

    assign tail_next = ring_next(r_tail);
    assign limit_x   = ({1'b0, i_cfg_scan_limit} > SCAN_MAX_X) ? SCAN_MAX_X
                                                               : {1'b0, i_cfg_scan_limit};
    assign can_issue = (r_rd_cnt < r_limit) && (r_rd_ptr != r_tail);
    assign hit       = r_cmp_vld && (r_rd_data == r_entry);
    assign issue     = i_cmd.scan_step && can_issue && !hit;

    // Status toward the controller.
    assign o_status.func      = r_func;
    assign o_status.empty     = (r_head == r_tail);
    assign o_status.timed_out = r_elapsed > {1'b0, i_cfg_timeout};
    assign o_status.hit       = hit;
    assign o_status.scan_idle = !can_issue && !r_cmp_vld;
    assign o_status.out_free  = !r_out_vld || i_m_tready;

    // Captured item; the entry is stored as type, code, value from the top bit down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_s_tuser;
            r_entry <= {i_s_tdata[15:0], i_s_tdata[31:16], i_s_tdata[63:32]};
        end
    end

    // Event memory: one write port for records, one registered read port for scans.
    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            r_mem[r_tail] <= r_entry;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // Ring pointers and elapsed-time counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_elapsed <= '0;
        end else begin
            if (i_cmd.record) begin
                // A full ring drops its oldest event.
                if (tail_next == r_head) begin
                    r_head <= ring_next(r_head);
                end
                r_tail    <= tail_next;
                r_elapsed <= '0;
            end else if (i_cmd.flush) begin
                r_head <= r_tail;
            end else if (i_cmd.scan_step && hit) begin
                // The match consumes itself and every entry before it.
                r_head <= ring_next(r_cmp_ptr);
            end
            if (i_cmd.tick && (r_elapsed != ieec_pkg::ELAPSED_MAX)) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
        end
    end

    // Scan pointers: a read goes out each cycle while the last read is compared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_ptr <= r_head;
            r_rd_cnt <= '0;
            r_limit  <= CNT_W'(limit_x);
        end else if (issue) begin
            r_rd_ptr  <= ring_next(r_rd_ptr);
            r_rd_cnt  <= r_rd_cnt + 1'b1;
            r_cmp_ptr <= r_rd_ptr;
        end
    end

    // Output register; it holds a result until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {i_cmd.res_flushed, i_cmd.res_matched};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(ieec_pkg::OUT_W - 2){1'b0}}, r_out_data};

endmodule

// File: rtl/injected_event_echo_canceller_core.sv
// Top level of the injected event echo canceller: register file, controller and datapath.
`timescale 1ns / 1ps

// The block takes one item at a time on the input stream and returns exactly one
// result for it. A record or a tick goes from the decode state to the result state. A
// check does the same on an empty ring or on timeout; otherwise it reads the ring from the
// head one entry per cycle through the single read port of the event memory until an
// entry matches, the scan limit is reached or the ring runs out, at most SCAN_MAX
// entries. The next item is taken while a result still waits in the output register. The
// event memory needs no clearing after reset; items are taken as soon as reset is
// released.
module injected_event_echo_canceller_core #(
    parameter int RING_DEPTH = 1024,
    parameter int SCAN_MAX   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: ev_type [15:0], ev_code [31:16], ev_value [63:32]
    input  logic [ieec_pkg::ENTRY_W-1:0]  s_axis_tdata,
    // tuser: func [1:0]
    input  logic [ieec_pkg::FUNC_W-1:0]   s_axis_tuser,
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: matched [0], flushed [1], zero [7:2]
    output logic [ieec_pkg::OUT_W-1:0]    m_axis_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ieec_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [ieec_pkg::SCAN_W-1:0]    r_scan_limit;
    logic [ieec_pkg::TIMEOUT_W-1:0] r_timeout;
    logic                           cfg_write;
    logic                           reg_sel;
    ieec_pkg::t_cmd                 cmd;
    ieec_pkg::t_status              status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= ieec_pkg::SCAN_LIMIT_RST;
            r_timeout    <= ieec_pkg::TIMEOUT_RST;
        end else if (cfg_write) begin
            unique case (reg_sel)
                ieec_pkg::REG_SCAN_LIMIT: r_scan_limit <= pwdata[ieec_pkg::SCAN_W-1:0];
                ieec_pkg::REG_TIMEOUT:    r_timeout    <= pwdata[ieec_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the configuration registers.
    always_comb begin
        unique case (reg_sel)
            ieec_pkg::REG_SCAN_LIMIT:
                prdata = {{(32 - ieec_pkg::SCAN_W){1'b0}}, r_scan_limit};
            ieec_pkg::REG_TIMEOUT:
                prdata = {{(32 - ieec_pkg::TIMEOUT_W){1'b0}}, r_timeout};
            default: prdata = '0;
        endcase
    end

    ieec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ieec_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .SCAN_MAX   (SCAN_MAX)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tdata        (s_axis_tdata),
        .i_s_tuser        (s_axis_tuser),
        .i_cfg_scan_limit (r_scan_limit),
        .i_cfg_timeout    (r_timeout),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_m_tready       (m_axis_tready),
        .o_m_tvalid       (m_axis_tvalid),
        .o_m_tdata        (m_axis_tdata)
    );

endmodule

// File: rtl/ieec_checker.sv
// Port-level checks for the echo canceller core, bound to the top level.
`timescale 1ns / 1ps

module ieec_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ieec_pkg::OUT_W-1:0]    m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A check never reports a match and a flush together.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("matched and flushed both set");

    // Padding bits of the result are zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ieec_pkg::OUT_W-1:2] == '0))
        else $error("nonzero padding in result");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The block works on one item at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new transfer taken while busy");

endmodule

bind injected_event_echo_canceller_core ieec_checker u_ieec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/tb.sv
// Self-checking testbench for the injected event echo canceller core.
`timescale 1ns / 1ps

module tb;

    localparam int RING_DEPTH       = 1024;
    localparam int SCAN_MAX         = 32;
    // Long enough for the longest check to finish, with margin on top.
    localparam int SETTLE_CYCLES    = SCAN_MAX + 8;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 70;
    localparam int RANDOM_PHASES    = 6;
    // Operation code outside the defined set; the block must ignore it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
    } t_event;

    typedef struct packed {
        logic matched;
        logic flushed;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // tdata: ev_type [15:0], ev_code [31:16], ev_value [63:32]
    logic [ieec_pkg::ENTRY_W-1:0] s_axis_tdata = '0;
    // tuser: func [1:0]
    logic [ieec_pkg::FUNC_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // tdata: matched [0], flushed [1], zero [7:2]
    logic [ieec_pkg::OUT_W-1:0] m_axis_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ieec_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Shadow state of the echo ring and its settings.
    t_event ring_mem [RING_DEPTH];
    int unsigned head_idx = 0;
    int unsigned tail_idx = 0;
    int unsigned elapsed_ms = 0;
    int unsigned scan_cfg = ieec_pkg::SCAN_LIMIT_RST;
    int unsigned timeout_cfg = ieec_pkg::TIMEOUT_RST;

    t_verdict verdict_q[$];
    int fail_count = 0;
    int n_records = 0;
    int n_checks = 0;
    int n_ticks = 0;
    int n_matches = 0;
    int n_flushes = 0;
    int n_settings = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;

    injected_event_echo_canceller_core #(
        .RING_DEPTH(RING_DEPTH),
        .SCAN_MAX  (SCAN_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Work out the verdict of one accepted item and update the shadow ring.
    function automatic t_verdict echo_predict(logic [1:0] func, t_event ev);
        t_verdict v;
        int unsigned lim;
        int unsigned idx;
        v = '0;
        case (func)
            ieec_pkg::FUNC_RECORD: begin
                n_records++;
                // A full ring drops its oldest event.
                if ((tail_idx + 1) % RING_DEPTH == head_idx)
                    head_idx = (head_idx + 1) % RING_DEPTH;
                ring_mem[tail_idx] = ev;
                tail_idx = (tail_idx + 1) % RING_DEPTH;
                elapsed_ms = 0;
            end
            ieec_pkg::FUNC_CHECK: begin
                n_checks++;
                if (head_idx != tail_idx) begin
                    if (elapsed_ms > timeout_cfg) begin
                        head_idx = tail_idx;
                        v.flushed = 1'b1;
                        n_flushes++;
                    end else begin
                        lim = (scan_cfg > SCAN_MAX) ? SCAN_MAX : scan_cfg;
                        idx = head_idx;
                        for (int n = 0; n < lim && idx != tail_idx; n++) begin
                            if (ring_mem[idx] == ev) begin
                                head_idx = (idx + 1) % RING_DEPTH;
                                v.matched = 1'b1;
                                n_matches++;
                                break;
                            end
                            idx = (idx + 1) % RING_DEPTH;
                        end
                    end
                end
            end
            ieec_pkg::FUNC_TICK: begin
                n_ticks++;
                if (elapsed_ms < ieec_pkg::ELAPSED_MAX)
                    elapsed_ms++;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_event fresh_event(int k);
        t_event ev;
        ev.ev_type = k[15:0];
        ev.ev_code = 16'hC3C3 ^ k[15:0];
        ev.ev_value = k * 32'h9E3779B1;
        return ev;
    endfunction

    // Mostly full-range events, sometimes from a tiny pool so that duplicates occur.
    function automatic t_event random_event();
        t_event ev;
        if ($urandom_range(0, 3) == 0) begin
            ev.ev_type = 16'($urandom_range(0, 1));
            ev.ev_code = 16'($urandom_range(0, 1));
            ev.ev_value = 32'($urandom_range(0, 2)) - 32'd1;
        end else begin
            ev.ev_type = 16'($urandom);
            ev.ev_code = 16'($urandom);
            ev.ev_value = $urandom;
        end
        return ev;
    endfunction

    // Send one item on the input stream; valid stays high after the transfer.
    task automatic send_item(input logic [1:0] func, input t_event ev);
        if (in_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {ev.ev_value, ev.ev_code, ev.ev_type};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdict_q.push_back(echo_predict(func, ev));
        @(negedge i_clk);
    endtask

    // Stop the input stream and wait until every result is back and the block is idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ieec_pkg::PADDR_W'({reg_idx, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (reg_idx == ieec_pkg::REG_SCAN_LIMIT)
            scan_cfg = value[ieec_pkg::SCAN_W-1:0];
        else
            timeout_cfg = value[ieec_pkg::TIMEOUT_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned scan, input int unsigned tmo);
        settle();
        apb_write(ieec_pkg::REG_SCAN_LIMIT, scan);
        apb_write(ieec_pkg::REG_TIMEOUT, tmo);
        n_settings++;
    endtask

    // Empty the ring through a forced timeout so a test starts from a known head.
    task automatic clear_ring();
        set_config(scan_cfg, 0);
        send_item(ieec_pkg::FUNC_RECORD, fresh_event(1));
        send_item(ieec_pkg::FUNC_TICK, fresh_event(2));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(3));
    endtask

    // Field extremes, every operation, empty ring, duplicates and an ignored code.
    task automatic test_basic_echo();
        t_event lo;
        t_event hi;
        t_event mix;
        t_event neg;
        lo = '{16'h0000, 16'h0000, 32'h8000_0000};
        hi = '{16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF};
        mix = '{16'hFFFF, 16'h0000, 32'h0000_0000};
        neg = '{16'h0000, 16'hFFFF, 32'hFFFF_FFFF};
        send_item(ieec_pkg::FUNC_CHECK, hi);
        send_item(ieec_pkg::FUNC_TICK, hi);
        send_item(FUNC_UNUSED, lo);
        send_item(ieec_pkg::FUNC_RECORD, lo);
        send_item(ieec_pkg::FUNC_RECORD, hi);
        send_item(ieec_pkg::FUNC_RECORD, mix);
        send_item(ieec_pkg::FUNC_RECORD, neg);
        send_item(ieec_pkg::FUNC_CHECK, hi);
        send_item(ieec_pkg::FUNC_CHECK, lo);
        send_item(ieec_pkg::FUNC_CHECK, '{16'hFFFF, 16'h0000, 32'h0000_0001});
        send_item(ieec_pkg::FUNC_CHECK, mix);
        send_item(FUNC_UNUSED, neg);
        send_item(ieec_pkg::FUNC_CHECK, neg);
        send_item(ieec_pkg::FUNC_RECORD, mix);
        send_item(ieec_pkg::FUNC_RECORD, mix);
        send_item(ieec_pkg::FUNC_CHECK, mix);
        send_item(ieec_pkg::FUNC_CHECK, mix);
        send_item(ieec_pkg::FUNC_CHECK, mix);
    endtask

    // Zero, one, full and oversized scan limits.
    task automatic test_scan_limit_edges();
        clear_ring();
        set_config(0, 65535);
        send_item(ieec_pkg::FUNC_RECORD, fresh_event(50));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(50));
        clear_ring();
        set_config(63, 65535);
        for (int k = 100; k < 140; k++) send_item(ieec_pkg::FUNC_RECORD, fresh_event(k));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(132));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(131));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(132));
        set_config(1, 65535);
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(134));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(133));
        set_config(32, 65535);
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(139));
    endtask

    // Timeout at zero, at the boundary and at its maximum.
    task automatic test_timeout_edges();
        clear_ring();
        set_config(24, 0);
        send_item(ieec_pkg::FUNC_RECORD, fresh_event(200));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(200));
        send_item(ieec_pkg::FUNC_RECORD, fresh_event(201));
        send_item(ieec_pkg::FUNC_TICK, fresh_event(0));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(201));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(201));
        set_config(24, 5);
        send_item(ieec_pkg::FUNC_RECORD, fresh_event(202));
        repeat (5) send_item(ieec_pkg::FUNC_TICK, fresh_event(0));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(202));
        send_item(ieec_pkg::FUNC_RECORD, fresh_event(203));
        repeat (6) send_item(ieec_pkg::FUNC_TICK, fresh_event(0));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(203));
        set_config(24, 65535);
        send_item(ieec_pkg::FUNC_RECORD, fresh_event(204));
        repeat (3) send_item(ieec_pkg::FUNC_TICK, fresh_event(0));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(204));
    endtask

    // Overfill the ring so the oldest events are overwritten and the pointers wrap.
    task automatic test_ring_wrap();
        clear_ring();
        set_config(24, 65535);
        for (int k = 2000; k < 2000 + RING_DEPTH + 1; k++)
            send_item(ieec_pkg::FUNC_RECORD, fresh_event(k));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(2000));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(2001));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(2002));
        send_item(ieec_pkg::FUNC_CHECK, fresh_event(2000 + RING_DEPTH));
    endtask

    // Random traffic in phases of different settings; mostly echoes of recorded events.
    task automatic test_random_traffic();
        int unsigned scans [RANDOM_PHASES];
        int unsigned tmos [RANDOM_PHASES];
        int sent;
        int pick;
        int depth;
        int span;
        int burst;
        t_event ev;
        scans = '{24, 1, 32, 63, 0, 24};
        tmos = '{2000, 0, 10, 65535, 3, 0};
        scans[RANDOM_PHASES-1] = $urandom_range(1, 32);
        tmos[RANDOM_PHASES-1] = $urandom_range(0, 30);
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config(scans[p], tmos[p]);
            // The last phase runs without any idling.
            in_idle_on = (p != RANDOM_PHASES - 1);
            out_idle_on = (p != RANDOM_PHASES - 1);
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                depth = (tail_idx + RING_DEPTH - head_idx) % RING_DEPTH;
                if (pick < 35) begin
                    send_item(ieec_pkg::FUNC_RECORD, random_event());
                    sent++;
                end else if (pick < 75 && depth > 0) begin
                    // Echo of a recorded event, at times just past the scan window.
                    span = (depth < 40) ? depth : 40;
                    ev = ring_mem[(head_idx + $urandom_range(0, span - 1)) % RING_DEPTH];
                    if ($urandom_range(0, 9) == 0)
                        ev.ev_value[$urandom_range(0, 31)] ^= 1'b1;
                    send_item(ieec_pkg::FUNC_CHECK, ev);
                    sent++;
                end else if (pick < 88) begin
                    send_item(ieec_pkg::FUNC_CHECK, random_event());
                    sent++;
                end else if (pick < 97) begin
                    burst = $urandom_range(1, 6);
                    repeat (burst) send_item(ieec_pkg::FUNC_TICK, random_event());
                    sent += burst;
                end else begin
                    send_item(FUNC_UNUSED, random_event());
                    sent++;
                end
            end
        end
    endtask

    // Result side: random stall bursts on the ready signal.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expected verdict.
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                fail_count++;
                $display("%0t: result with nothing expected, actual tdata=%h",
                         $time, m_axis_tdata);
            end else begin
                v = verdict_q.pop_front();
                if (m_axis_tdata[0] !== v.matched || m_axis_tdata[1] !== v.flushed
                    || m_axis_tdata[ieec_pkg::OUT_W-1:2] !== '0) begin
                    fail_count++;
                    $display("%0t: mismatch, expected matched=%0b flushed=%0b,",
                             $time, v.matched, v.flushed);
                    $display("    actual matched=%0b flushed=%0b (tdata=%h)",
                             m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL injected_event_echo_canceller_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_echo();
        test_scan_limit_edges();
        test_timeout_edges();
        test_ring_wrap();
        test_random_traffic();
        settle();
        $display("Covered %0d records, %0d checks and %0d ticks over %0d register settings.",
                 n_records, n_checks, n_ticks, n_settings);
        $display("Checks gave %0d echo matches and %0d timeout flushes; %0d mismatches.",
                 n_matches, n_flushes, fail_count);
        if (fail_count == 0) begin
            $display("PASS injected_event_echo_canceller_core");
        end else begin
            $display("FAIL injected_event_echo_canceller_core");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ieec_pkg.sv
rtl/ieec_ctrl.sv
rtl/ieec_datapath.sv
rtl/injected_event_echo_canceller_core.sv
rtl/ieec_checker.sv
test/tb.sv
